// ----- rtl/hbpf_pkg.sv -----
package hbpf_pkg;

  // request kinds carried on in_tuser
  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RECT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_IMG   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

  // input field widths
  localparam int XIN_W   = 7;
  localparam int YIN_W   = 6;
  localparam int WIN_W   = 7;
  localparam int HIN_W   = 6;
  localparam int COLOR_W = 8;
  localparam int NIB_W   = 4;

  // internal pixel coordinates, wide enough for origin plus size
  localparam int PX_W = 8;
  localparam int PY_W = 8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // only the pixel byte of a cell is stored; the low byte is always this glyph
  localparam int CELL_HI_W = 2 * NIB_W;
  localparam logic [7:0] BLANK_GLYPH = 8'hDF;
  localparam logic [CELL_HI_W-1:0] BLANK_PIXELS = '0;

endpackage

// ----- rtl/hbpf_ram.sv -----
module hbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/half_block_pixel_framebuffer.sv -----
// Half-block pixel frame buffer: COLUMNS x CELL_ROWS text cells, each holding two
// 4-bit pixels (even pixel row in bits 11:8, odd row in bits 15:12; the low byte
// is always 0xDF), so the pixel screen is COLUMNS wide and 2*CELL_ROWS high. Only
// the pixel byte of each cell is kept, in one RAM with one write and one
// registered read port. Every request gives exactly one result item. Steps, from
// accept to result: put and a drawn image pixel read the cell, then modify and
// write it back; get reads the cell and returns its pixel; image start and any
// request that draws nothing finish straight from idle; a rectangle reads, then
// modifies and writes back, each on-screen pixel in turn, since each pixel is its
// own read-modify-write through the single RAM; clear writes every cell, one cell
// written per cycle. After reset the block sweeps the RAM with in_tready low. One
// request is worked on at a time; a new one is accepted while the previous result
// waits in the output register.
module half_block_pixel_framebuffer
  import hbpf_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int CELL_ROWS = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // x_pos, y_pos, width, height, pixel_color, zero pad
  input  logic [REQ_W-1:0]       in_tuser,  // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // read_color, rejected, zero pad
  output logic                   out_tlast  // image_complete
);

  localparam int CELL_COUNT = COLUMNS * CELL_ROWS;
  localparam int PIXEL_ROWS = 2 * CELL_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);

  localparam logic [PX_W-1:0] X_LIMIT   = PX_W'(COLUMNS);
  localparam logic [PY_W-1:0] Y_LIMIT   = PY_W'(PIXEL_ROWS);
  localparam logic [AW-1:0]   LAST_CELL = AW'(CELL_COUNT - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [PX_W-1:0] px,
                                               input logic [PY_W-1:0] py);
    logic [AW-1:0] row;
    row = AW'(py >> 1);
    return row * AW'(COLUMNS) + AW'(px);
  endfunction

  // input fields
  logic [XIN_W-1:0]   in_x;
  logic [YIN_W-1:0]   in_y;
  logic [WIN_W-1:0]   in_w;
  logic [HIN_W-1:0]   in_h;
  logic [COLOR_W-1:0] in_color;
  logic [PX_W-1:0]    in_px;
  logic [PY_W-1:0]    in_py;

  assign in_x     = in_tdata[6:0];
  assign in_y     = in_tdata[12:7];
  assign in_w     = in_tdata[19:13];
  assign in_h     = in_tdata[25:20];
  assign in_color = in_tdata[33:26];
  assign in_px    = PX_W'(in_x);
  assign in_py    = PY_W'(in_y);

  // control and stored state
  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [REQ_W-1:0]   op_r, op_nxt;
  logic [AW-1:0]      op_addr_r, op_addr_nxt;
  logic               op_odd_r, op_odd_nxt;
  logic [NIB_W-1:0]   op_color_r, op_color_nxt;
  logic [PX_W-1:0]    rx0_r, rx0_nxt, rpx_r, rpx_nxt, rxe_r, rxe_nxt;
  logic [PY_W-1:0]    rpy_r, rpy_nxt, rye_r, rye_nxt;
  logic [PX_W-1:0]    org_x_r, org_x_nxt, img_x_r, img_x_nxt;
  logic [PY_W-1:0]    org_y_r, org_y_nxt, img_y_r, img_y_nxt;
  logic [WIN_W-1:0]   img_w_r, img_w_nxt, img_col_r, img_col_nxt;
  logic [HIN_W-1:0]   img_h_r, img_h_nxt, img_row_r, img_row_nxt;
  logic               img_act_r, img_act_nxt;
  logic [NIB_W-1:0]   res_color_r, res_color_nxt;
  logic               res_rej_r, res_rej_nxt;
  logic               res_cmp_r, res_cmp_nxt;
  logic               out_valid_r;
  logic [NIB_W-1:0]   out_color_r;
  logic               out_rej_r, out_last_r;

  // ram port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CELL_HI_W-1:0] ram_wdata, ram_rdata;

  // request decode
  logic            accept, finish, out_free;
  logic            color_ok, pix_on, img_on, rect_off, rect_draw;
  logic [PX_W-1:0] rx_sum, rx_end;
  logic [PY_W-1:0] ry_sum, ry_end;
  logic [PX_W-1:0] col_inc;
  logic [PY_W-1:0] row_inc;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign color_ok  = (in_color[COLOR_W-1:NIB_W] == '0);
  assign pix_on    = (in_px < X_LIMIT) && (in_py < Y_LIMIT);
  assign img_on    = (img_x_r < X_LIMIT) && (img_y_r < Y_LIMIT);

  // rectangle clipped to the screen; partly off-screen still draws the visible part
  assign rx_sum    = in_px + PX_W'(in_w);
  assign ry_sum    = in_py + PY_W'(in_h);
  assign rx_end    = (rx_sum > X_LIMIT) ? X_LIMIT : rx_sum;
  assign ry_end    = (ry_sum > Y_LIMIT) ? Y_LIMIT : ry_sum;
  assign rect_off  = (in_w != '0) && (in_h != '0) && ((rx_sum > X_LIMIT) || (ry_sum > Y_LIMIT));
  assign rect_draw = color_ok && (in_px < rx_end) && (in_py < ry_end);

  assign col_inc   = PX_W'(img_col_r) + PX_W'(1);
  assign row_inc   = PY_W'(img_row_r) + PY_W'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    op_addr_nxt   = op_addr_r;
    op_odd_nxt    = op_odd_r;
    op_color_nxt  = op_color_r;
    rx0_nxt       = rx0_r;
    rpx_nxt       = rpx_r;
    rxe_nxt       = rxe_r;
    rpy_nxt       = rpy_r;
    rye_nxt       = rye_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    img_x_nxt     = img_x_r;
    img_y_nxt     = img_y_r;
    img_w_nxt     = img_w_r;
    img_h_nxt     = img_h_r;
    img_col_nxt   = img_col_r;
    img_row_nxt   = img_row_r;
    img_act_nxt   = img_act_r;
    res_color_nxt = res_color_r;
    res_rej_nxt   = res_rej_r;
    res_cmp_nxt   = res_cmp_r;
    ram_we        = 1'b0;
    ram_waddr     = op_addr_r;
    ram_wdata     = BLANK_PIXELS;
    ram_raddr     = cell_addr(in_px, in_py);
    finish        = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tuser == REQ_IMG) begin
          ram_raddr = cell_addr(img_x_r, img_y_r);
        end
        if (accept) begin
          res_color_nxt = '0;
          res_rej_nxt   = 1'b0;
          res_cmp_nxt   = 1'b0;
          op_nxt        = in_tuser;
          op_addr_nxt   = cell_addr(in_px, in_py);
          op_odd_nxt    = in_y[0];
          op_color_nxt  = in_color[NIB_W-1:0];
          unique case (in_tuser)
            REQ_PUT: begin
              if (color_ok && pix_on) begin
                state_nxt = S_RMW;
              end else begin
                res_rej_nxt = 1'b1;
                finish      = 1'b1;
              end
            end
            REQ_GET: begin
              if (pix_on) begin
                state_nxt = S_RMW;
              end else begin
                res_rej_nxt = 1'b1;
                finish      = 1'b1;
              end
            end
            REQ_RECT: begin
              res_rej_nxt = !color_ok || rect_off;
              rx0_nxt     = in_px;
              rpx_nxt     = in_px;
              rxe_nxt     = rx_end;
              rpy_nxt     = in_py;
              rye_nxt     = ry_end;
              if (rect_draw) begin
                state_nxt = S_RD;
              end else begin
                finish = 1'b1;
              end
            end
            REQ_START: begin
              org_x_nxt   = in_px;
              org_y_nxt   = in_py;
              img_x_nxt   = in_px;
              img_y_nxt   = in_py;
              img_w_nxt   = in_w;
              img_h_nxt   = in_h;
              img_col_nxt = '0;
              img_row_nxt = '0;
              img_act_nxt = (in_w != '0) && (in_h != '0);
              finish      = 1'b1;
            end
            REQ_IMG: begin
              if (!img_act_r) begin
                res_rej_nxt = 1'b1;
                finish      = 1'b1;
              end else begin
                op_addr_nxt = cell_addr(img_x_r, img_y_r);
                op_odd_nxt  = img_y_r[0];
                // the stream advances whether or not the pixel lands
                if (col_inc >= PX_W'(img_w_r)) begin
                  img_col_nxt = '0;
                  img_x_nxt   = org_x_r;
                  if (row_inc >= PY_W'(img_h_r)) begin
                    img_row_nxt = '0;
                    img_y_nxt   = org_y_r;
                    img_act_nxt = 1'b0;
                    res_cmp_nxt = 1'b1;
                  end else begin
                    img_row_nxt = row_inc[HIN_W-1:0];
                    img_y_nxt   = img_y_r + PY_W'(1);
                  end
                end else begin
                  img_col_nxt = col_inc[WIN_W-1:0];
                  img_x_nxt   = img_x_r + PX_W'(1);
                end
                if (color_ok && img_on) begin
                  state_nxt = S_RMW;
                end else begin
                  res_rej_nxt = 1'b1;
                  finish      = 1'b1;
                end
              end
            end
            REQ_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            default: begin
              res_rej_nxt = 1'b1;
              finish      = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        ram_raddr   = cell_addr(rpx_r, rpy_r);
        op_addr_nxt = cell_addr(rpx_r, rpy_r);
        op_odd_nxt  = rpy_r[0];
        state_nxt   = S_RMW;
      end

      S_RMW: begin
        if (op_r == REQ_GET) begin
          res_color_nxt = op_odd_r ? ram_rdata[CELL_HI_W-1:NIB_W] : ram_rdata[NIB_W-1:0];
          finish        = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = op_odd_r ? {op_color_r, ram_rdata[NIB_W-1:0]}
                               : {ram_rdata[CELL_HI_W-1:NIB_W], op_color_r};
          if (op_r == REQ_RECT) begin
            if ((rpx_r + PX_W'(1)) < rxe_r) begin
              rpx_nxt   = rpx_r + PX_W'(1);
              state_nxt = S_RD;
            end else if ((rpy_r + PY_W'(1)) < rye_r) begin
              rpx_nxt   = rx0_r;
              rpy_nxt   = rpy_r + PY_W'(1);
              state_nxt = S_RD;
            end else begin
              finish = 1'b1;
            end
          end else begin
            finish = 1'b1;
          end
        end
      end

      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_CELL) begin
          finish = 1'b1;
        end
      end

      S_HOLD: begin
        finish = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result goes straight out if the output register is free, else it waits
    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      img_x_r     <= '0;
      img_y_r     <= '0;
      img_w_r     <= '0;
      img_h_r     <= '0;
      img_col_r   <= '0;
      img_row_r   <= '0;
      img_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      img_x_r     <= img_x_nxt;
      img_y_r     <= img_y_nxt;
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
      img_col_r   <= img_col_nxt;
      img_row_r   <= img_row_nxt;
      img_act_r   <= img_act_nxt;
      if (finish && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    op_addr_r   <= op_addr_nxt;
    op_odd_r    <= op_odd_nxt;
    op_color_r  <= op_color_nxt;
    rx0_r       <= rx0_nxt;
    rpx_r       <= rpx_nxt;
    rxe_r       <= rxe_nxt;
    rpy_r       <= rpy_nxt;
    rye_r       <= rye_nxt;
    res_color_r <= res_color_nxt;
    res_rej_r   <= res_rej_nxt;
    res_cmp_r   <= res_cmp_nxt;
    if (finish && out_free) begin
      out_color_r <= res_color_nxt;
      out_rej_r   <= res_rej_nxt;
      out_last_r  <= res_cmp_nxt;
    end
  end

  hbpf_ram #(
    .WIDTH(CELL_HI_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - NIB_W - 1)'(0), out_rej_r, out_color_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/hbpf_checker.sv -----
module hbpf_checker
  import hbpf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // items taken in but whose result has not left yet
  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r < 2'd2)
    else $error("item accepted with a result already waiting and one in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result item with no request behind it");

  a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[NIB_W-1:0] == '0)
    else $error("image end item carries a read color");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:NIB_W+1] == '0)
    else $error("pad bits of result item not zero");

endmodule

bind half_block_pixel_framebuffer hbpf_checker u_hbpf_checker (.*);
